### src/mvm8x6_pkg.sv
// Package with the constants, word types and inter-cell types of the matrix-vector multiplier.
`default_nettype none
package mvm8x6_pkg;

    localparam int ROWS       = 8;
    localparam int COLS       = 6;
    localparam int DATA_WIDTH = 16;
    localparam int SUM_W      = 32;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W      = 3;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [ROW_W-1:0]             t_row;

    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    row_index;
        logic [IDX_W-1:0]    col_index;
        logic signed [15:0]  coeff_value;
        logic signed [15:0]  vec_0;
        logic signed [15:0]  vec_1;
        logic signed [15:0]  vec_2;
        logic signed [15:0]  vec_3;
        logic signed [15:0]  vec_4;
        logic signed [15:0]  vec_5;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic signed [31:0] out_4;
        logic signed [31:0] out_5;
        logic signed [31:0] out_6;
        logic signed [31:0] out_7;
    } t_out_word;

    typedef struct packed {
        logic  en;
        t_row  row;
        t_coef value;
    } t_wr;

    typedef struct packed {
        logic valid;
        t_row row;
        t_sum sum;
    } t_link;

endpackage
`default_nettype wire

### src/matrix_vector_multiply_8x6.sv
// Top level of the matrix-vector multiplier: word handshakes, row sequencing, cell chain and result collection.
`default_nettype none
// A write word stores one signed coefficient; writes to a row or column outside the table are
// dropped. A compute word loads the six vector elements into a chain of six column cells, then
// one table row enters the chain per cycle and its running sum passes one cell per cycle, each
// cell adding one product. A compute word keeps the block busy while the rows are issued, while
// the last row crosses the chain and until the finished result is handed to the output register.
// The result register holds the word until it is taken while new words are accepted. The
// coefficient table is cleared by reset.
module matrix_vector_multiply_8x6 (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire mvm8x6_pkg::t_in_word    i_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output mvm8x6_pkg::t_out_word        o_data
);
    import mvm8x6_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_HOLD
    } t_state;

    t_state    r_state;
    t_row      r_feed;
    t_sum      r_res [ROWS];
    logic      r_out_valid;
    t_out_word r_data;

    logic      w_accept;
    logic      w_load;
    logic      w_wr_ok;
    logic [COLS-1:0] w_wr_en;
    t_wr       w_wr [COLS];
    t_coef     w_vec [6];
    t_link     w_link [COLS+1];
    logic      w_last_out;
    logic      w_send;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && (i_data.opcode == OP_COMPUTE);
    assign w_wr_ok  = w_accept && (i_data.opcode == OP_WRITE)
                      && (32'(i_data.row_index) < ROWS) && (32'(i_data.col_index) < COLS);

    always_comb begin
        w_vec[0] = i_data.vec_0;
        w_vec[1] = i_data.vec_1;
        w_vec[2] = i_data.vec_2;
        w_vec[3] = i_data.vec_3;
        w_vec[4] = i_data.vec_4;
        w_vec[5] = i_data.vec_5;
        for (int c = 0; c < COLS; c++) begin
            w_wr_en[c]     = w_wr_ok && (32'(i_data.col_index) == c);
            w_wr[c].en     = w_wr_en[c];
            w_wr[c].row    = ROW_W'(i_data.row_index);
            w_wr[c].value  = i_data.coeff_value;
        end
    end

    assign w_link[0].valid = (r_state == S_FEED);
    assign w_link[0].row   = r_feed;
    assign w_link[0].sum   = '0;

    for (genvar c = 0; c < COLS; c++) begin : g_cell
        mvm8x6_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[c]),
            .i_load  (w_load),
            .i_vec   (w_vec[c]),
            .i_link  (w_link[c]),
            .o_link  (w_link[c+1])
        );
    end

    assign w_last_out = w_link[COLS].valid && (w_link[COLS].row == ROW_W'(ROWS - 1));
    assign w_send     = (r_state == S_HOLD) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (w_link[COLS].valid) begin
            r_res[w_link[COLS].row] <= w_link[COLS].sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_feed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_send) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_feed <= '0;
                    if (w_load) begin
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    if (r_feed == ROW_W'(ROWS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_feed <= r_feed + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_last_out) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_send) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_send) begin
            r_data.out_0 <= r_res[0];
            r_data.out_1 <= r_res[1];
            r_data.out_2 <= r_res[2];
            r_data.out_3 <= r_res[3];
            r_data.out_4 <= r_res[4];
            r_data.out_5 <= r_res[5];
            r_data.out_6 <= r_res[6];
            r_data.out_7 <= r_res[7];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_data;

    a_exit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[COLS].valid |-> (r_state == S_FEED || r_state == S_DRAIN))
        else $error("row sum left the chain outside a computation");

    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_HOLD))
        else $error("result word raised without a finished computation");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_wr_en) |-> ($onehot(w_wr_en) && r_state == S_IDLE))
        else $error("coefficient write while busy or to several columns");

endmodule
`default_nettype wire

### src/mvm8x6_cell.sv
// One column cell: holds a coefficient column and a vector element, and adds its product to the passing row sum.
`default_nettype none
module mvm8x6_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire mvm8x6_pkg::t_wr      i_wr,
    input  wire                       i_load,
    input  wire mvm8x6_pkg::t_coef    i_vec,
    input  wire mvm8x6_pkg::t_link    i_link,
    output mvm8x6_pkg::t_link         o_link
);
    import mvm8x6_pkg::*;

    t_coef r_coef [ROWS];
    t_coef r_vec;
    t_link r_link;

    logic signed [2*DATA_WIDTH-1:0] w_prod;
    t_sum                           n_sum;

    always_comb begin
        w_prod = r_coef[i_link.row] * r_vec;
        n_sum  = i_link.sum + SUM_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_coef[r] <= '0;
            end
            r_link.valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_coef[i_wr.row] <= i_wr.value;
            end
            r_link.valid <= i_link.valid;
        end
        if (i_load) begin
            r_vec <= i_vec;
        end
        r_link.row <= i_link.row;
        r_link.sum <= n_sum;
    end

    assign o_link = r_link;

endmodule
`default_nettype wire

### sim/mvm8x6_product_checker.sv
// Checker that watches both word channels of the multiplier, predicts each product and compares it.
module mvm8x6_product_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_in_stall,
    input  mvm8x6_pkg::t_in_word    i_in_word,
    input  wire                     i_out_valid,
    input  wire                     i_out_stall,
    input  mvm8x6_pkg::t_out_word   i_out_word,
    output int                      o_mismatch_count,
    output int                      o_products_due
);
    import mvm8x6_pkg::*;

    t_coef     coeff_table [ROWS][COLS];
    t_out_word products_due [$];

    initial begin
        o_mismatch_count = 0;
        o_products_due   = 0;
    end

    function automatic t_out_word table_times_vector(input t_in_word w);
        t_coef                        vec [COLS];
        logic [0:ROWS-1][SUM_W-1:0]   sums;
        t_sum                         acc;
        vec[0] = w.vec_0;
        vec[1] = w.vec_1;
        vec[2] = w.vec_2;
        vec[3] = w.vec_3;
        vec[4] = w.vec_4;
        vec[5] = w.vec_5;
        for (int r = 0; r < ROWS; r++) begin
            acc = '0;
            for (int c = 0; c < COLS; c++)
                acc += t_sum'(coeff_table[r][c]) * t_sum'(vec[c]);
            sums[r] = acc;
        end
        return t_out_word'(sums);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word                  expected;
        logic [0:ROWS-1][SUM_W-1:0] exp_rows;
        logic [0:ROWS-1][SUM_W-1:0] got_rows;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    coeff_table[r][c] = '0;
            products_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_rows = i_out_word;
                if (products_due.size() == 0) begin
                    o_mismatch_count++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_out_word);
                end else begin
                    expected = products_due.pop_front();
                    exp_rows = expected;
                    for (int r = 0; r < ROWS; r++) begin
                        if (got_rows[r] !== exp_rows[r]) begin
                            o_mismatch_count++;
                            $display("%0t: out_%0d mismatch, expected %0d, got %0d",
                                     $time, r, $signed(exp_rows[r]), $signed(got_rows[r]));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.opcode == OP_WRITE) begin
                    if (i_in_word.row_index < ROWS && i_in_word.col_index < COLS)
                        coeff_table[i_in_word.row_index][i_in_word.col_index] =
                            i_in_word.coeff_value;
                end else begin
                    products_due.push_back(table_times_vector(i_in_word));
                end
            end
        end
        o_products_due = products_due.size();
    end

endmodule

### sim/tb_matrix_vector_multiply_8x6.sv
// Testbench top for the matrix-vector multiplier: clock, reset, word stimulus, back-pressure and verdict.
module tb_matrix_vector_multiply_8x6;
    import mvm8x6_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1100;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    int        mismatch_count;
    int        products_due;
    int        gap_max   = 12;
    int        stall_max = 12;
    int        cycle_count = 0;

    matrix_vector_multiply_8x6 u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_word)
    );

    mvm8x6_product_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_word        (in_word),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_word       (out_word),
        .o_mismatch_count (mismatch_count),
        .o_products_due   (products_due)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.opcode      = 1'($urandom);
        w.row_index   = 3'($urandom);
        w.col_index   = 3'($urandom);
        w.coeff_value = pick_value();
        w.vec_0       = pick_value();
        w.vec_1       = pick_value();
        w.vec_2       = pick_value();
        w.vec_3       = pick_value();
        w.vec_4       = pick_value();
        w.vec_5       = pick_value();
        return w;
    endfunction

    function automatic t_in_word write_word(input int r, input int c,
                                            input logic signed [15:0] v);
        t_in_word w;
        w             = random_word();
        w.opcode      = OP_WRITE;
        w.row_index   = 3'(r);
        w.col_index   = 3'(c);
        w.coeff_value = v;
        return w;
    endfunction

    function automatic t_in_word compute_word(input logic signed [15:0] v);
        t_in_word w;
        w        = random_word();
        w.opcode = OP_COMPUTE;
        w.vec_0  = v;
        w.vec_1  = v;
        w.vec_2  = v;
        w.vec_3  = v;
        w.vec_4  = v;
        w.vec_5  = v;
        return w;
    endfunction

    // Returns just after the rising edge at which the word was taken.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_word  <= random_word();
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_for_products();
        @(negedge clk);
        in_valid <= 1'b0;
        in_word  <= random_word();
        while (products_due != 0) @(negedge clk);
    endtask

    initial begin : result_sink
        int n;
        forever begin
            n = $urandom_range(0, stall_max);
            @(negedge clk);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        t_in_word w;
        int       pick;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(compute_word(16'sh7fff));
        send_word(write_word(0, 0, 16'sh8000));
        send_word(write_word(7, 5, 16'sh7fff));
        send_word(write_word(3, 2, 16'shffff));
        send_word(write_word(7, 6, 16'sh1234));
        send_word(write_word(0, 7, 16'sh7fff));
        send_word(compute_word(16'sh8000));
        for (int c = 0; c < COLS; c++)
            send_word(write_word(5, c, 16'sh8000));
        send_word(compute_word(16'sh8000));
        send_word(compute_word(16'sh7fff));
        w        = random_word();
        w.opcode = OP_COMPUTE;
        send_word(w);
        wait_for_products();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 150 == 0) begin
                case ((i / 150) % 5)
                    0: begin gap_max = 12; stall_max = 12; end
                    1: begin gap_max = 0;  stall_max = 0;  end
                    2: begin gap_max = 3;  stall_max = 12; end
                    3: begin gap_max = 12; stall_max = 0;  end
                    default: begin gap_max = 0; stall_max = 3; end
                endcase
            end
            if (i > 0 && i % 250 == 0)
                wait_for_products();
            pick = $urandom_range(0, 99);
            w    = random_word();
            if (pick < 35)
                w.opcode = OP_COMPUTE;
            else if (pick < 45)
                w = write_word($urandom_range(0, 7), $urandom_range(COLS, 7), pick_value());
            else
                w = write_word($urandom_range(0, 7), $urandom_range(0, COLS - 1),
                               pick_value());
            send_word(w);
        end

        wait_for_products();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && products_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
